// ----- hdl/eds_pkg.sv -----
// Shared types, constants and the cell function of the edit-distance block.
package eds_pkg;

  localparam int MAX_LEN = 64;
  localparam int CHAR_W  = 8;
  localparam int DIST_W  = 7;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int BANK_W  = 2;
  localparam int ROW_AW  = BANK_W + CNT_W;

  localparam logic [1:0] ACT_SRC = 2'd0;
  localparam logic [1:0] ACT_TGT = 2'd1;
  localparam logic [1:0] ACT_RUN = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [CHAR_W-1:0] char_in;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ROW_AW-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic [ROW_AW-1:0] raddr_one;
    logic [ROW_AW-1:0] raddr_two;
  } row_req_t;

  // one DP cell: insert, delete, substitute, and adjacent swap when allowed
  function automatic logic [CNT_W-1:0] eds_cell(
    input logic [CNT_W-1:0]  up,
    input logic [CNT_W-1:0]  left,
    input logic [CNT_W-1:0]  diag,
    input logic [CNT_W-1:0]  two_back,
    input logic [CHAR_W-1:0] si,
    input logic [CHAR_W-1:0] tj,
    input logic [CHAR_W-1:0] si_prev,
    input logic [CHAR_W-1:0] tj_prev,
    input logic              swap_ok
  );
    logic [CNT_W+1:0] a;
    logic [CNT_W+1:0] b;
    logic [CNT_W+1:0] c;
    logic [CNT_W+1:0] s;
    logic [CNT_W+1:0] m;
    a = (CNT_W+2)'(up) + (CNT_W+2)'(1);
    b = (CNT_W+2)'(left) + (CNT_W+2)'(1);
    c = (CNT_W+2)'(diag) + (CNT_W+2)'(si != tj);
    s = (CNT_W+2)'(two_back) + (CNT_W+2)'(1) + (CNT_W+2)'(si_prev != tj)
      + (CNT_W+2)'(si != tj_prev);
    m = (a < b) ? a : b;
    m = (c < m) ? c : m;
    if (swap_ok && (s < m)) begin
      m = s;
    end
    return m[CNT_W-1:0];
  endfunction

endpackage

// ----- hdl/edit_distance_with_swaps_top.sv -----
// Top level of the optimal-string-alignment edit-distance block.
// Append items (action 0 to source, 1 to target) never raise busy. A compute
// item (action 2) raises busy while the row sweep runs: for each source row a
// setup state (S_ROW) fetches the source character, then the row's cells are
// computed one DP cell per cycle from the row store. With either string empty
// the result comes the cycle after the transfer. The result appears on result
// with done high for exactly one cycle and must be taken then; both strings
// and the overflow flag are cleared at the same time. Characters beyond 64 per
// string are dropped and flagged in result.overflow.
module edit_distance_with_swaps_top
  import eds_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROW  = 3'b010,
    S_CELL = 3'b100
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  m;
  logic              ovf;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  left;
  logic [CNT_W-1:0]  diag;
  logic [CHAR_W-1:0] tprev;
  logic [CHAR_W-1:0] sprev;
  logic [BANK_W-1:0] b_now;
  logic [BANK_W-1:0] b_one;
  logic [BANK_W-1:0] b_two;

  logic [CHAR_W-1:0] source_text [0:MAX_LEN-1];
  logic [CHAR_W-1:0] target_text [0:MAX_LEN-1];
  logic [CHAR_W-1:0] src_q;
  logic [CHAR_W-1:0] tgt_q;

  logic             take;
  logic [CNT_W-1:0] ja;
  logic [CNT_W-1:0] src_ra;
  logic [CNT_W-1:0] tgt_ra;
  logic [CNT_W-1:0] up;
  logic [CNT_W-1:0] two_back;
  logic [CNT_W-1:0] rd_one;
  logic [CNT_W-1:0] rd_two;
  logic [CNT_W-1:0] cost;
  logic             swap_ok;
  logic             src_wr;
  logic             tgt_wr;
  row_req_t         rreq;

  assign busy   = (state != S_IDLE);
  assign take   = start && !busy;
  assign src_wr = take && (item.action == ACT_SRC) && (n < CNT_W'(MAX_LEN));
  assign tgt_wr = take && (item.action == ACT_TGT) && (m < CNT_W'(MAX_LEN));

  // column whose operands are fetched this cycle
  assign ja     = (state == S_ROW) ? CNT_W'(1) : CNT_W'(j + CNT_W'(1));
  assign src_ra = CNT_W'(i - CNT_W'(1));
  assign tgt_ra = CNT_W'(ja - CNT_W'(1));

  // row 0 and column 0 are never stored
  assign up       = (i == CNT_W'(1)) ? j : rd_one;
  assign two_back = (i == CNT_W'(2)) ? CNT_W'(j - CNT_W'(2)) :
                    (j == CNT_W'(2)) ? CNT_W'(i - CNT_W'(2)) : rd_two;
  assign swap_ok  = (i >= CNT_W'(2)) && (j >= CNT_W'(2));
  assign cost     = eds_cell(up, left, diag, two_back, src_q, tgt_q, sprev, tprev,
                             swap_ok);

  always_comb begin
    rreq.we        = (state == S_CELL);
    rreq.waddr     = {b_now, j};
    rreq.wdata     = cost;
    rreq.raddr_one = {b_one, ja};
    rreq.raddr_two = {b_two, CNT_W'(ja - CNT_W'(2))};
  end

  eds_row_store u_rows (
    .clk    (clk),
    .req    (rreq),
    .rd_one (rd_one),
    .rd_two (rd_two)
  );

  always_ff @(posedge clk) begin
    if (src_wr) begin
      source_text[n[IDX_W-1:0]] <= item.char_in;
    end
    if (tgt_wr) begin
      target_text[m[IDX_W-1:0]] <= item.char_in;
    end
    if (state == S_ROW) begin
      src_q <= source_text[src_ra[IDX_W-1:0]];
    end
    tgt_q <= target_text[tgt_ra[IDX_W-1:0]];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      m     <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            case (item.action)
              ACT_SRC: begin
                if (src_wr) n <= CNT_W'(n + CNT_W'(1));
                else ovf <= 1'b1;
              end
              ACT_TGT: begin
                if (tgt_wr) m <= CNT_W'(m + CNT_W'(1));
                else ovf <= 1'b1;
              end
              ACT_RUN: begin
                if ((n == '0) || (m == '0)) begin
                  done <= 1'b1;
                  n    <= '0;
                  m    <= '0;
                  ovf  <= 1'b0;
                end else begin
                  state <= S_ROW;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ROW: begin
          state <= S_CELL;
        end
        S_CELL: begin
          if (j == m) begin
            if (i == n) begin
              done  <= 1'b1;
              n     <= '0;
              m     <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_ROW;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        i     <= CNT_W'(1);
        b_now <= BANK_W'(0);
        b_one <= BANK_W'(2);
        b_two <= BANK_W'(1);
        if (take && (item.action == ACT_RUN)) begin
          result.distance <= (n == '0) ? DIST_W'(m) : DIST_W'(n);
          result.overflow <= ovf;
        end
      end
      S_ROW: begin
        j    <= CNT_W'(1);
        left <= i;
        diag <= CNT_W'(i - CNT_W'(1));
      end
      S_CELL: begin
        left  <= cost;
        diag  <= up;
        tprev <= tgt_q;
        if (j == m) begin
          if (i == n) begin
            result.distance <= DIST_W'(cost);
            result.overflow <= ovf;
          end else begin
            i     <= CNT_W'(i + CNT_W'(1));
            sprev <= src_q;
            b_now <= b_two;
            b_one <= b_now;
            b_two <= b_one;
          end
        end else begin
          j <= CNT_W'(j + CNT_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/eds_row_store.sv -----
// Three-bank ring of DP rows: one write port, two registered read ports.
module eds_row_store
  import eds_pkg::*;
(
  input  logic             clk,
  input  row_req_t         req,
  output logic [CNT_W-1:0] rd_one,
  output logic [CNT_W-1:0] rd_two
);

  logic [CNT_W-1:0] rows [0:(1 << ROW_AW) - 1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      rows[req.waddr] <= req.wdata;
    end
    rd_one <= rows[req.raddr_one];
    rd_two <= rows[req.raddr_two];
  end

endmodule
